// ===== sv/pvs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvs_pkg: shared types and helpers for the polynomial value and slope block
// Q16.16 saturation helpers, the lane record that runs along the cell chain,
// and the configuration register indexes.
// ----------------------------------------------------------------------------
package pvs_pkg;

   localparam int MAX_TERMS = 6;   // default for the top level parameter
   localparam int COEF_REGS = 6;   // coefficient registers that exist
   localparam int DATA_W    = 32;
   localparam int TERM_W    = 3;
   localparam int IDX_W     = 3;
   localparam int FRAC_W    = 16;
   localparam int RSP_W     = 72;  // value, slope, overflow, byte padding

   typedef enum logic [IDX_W-1:0] {
      REG_TERM_COUNT = 3'd0,
      REG_COEF_0     = 3'd1,
      REG_COEF_1     = 3'd2,
      REG_COEF_2     = 3'd3,
      REG_COEF_3     = 3'd4,
      REG_COEF_4     = 3'd5,
      REG_COEF_5     = 3'd6,
      REG_NONE       = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic                     ov;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] slope;
      logic                     ov;
   } lane_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      r.ov  = 1'b0;
      r.val = v[DATA_W-1:0];
      if (v > 64'sd2147483647) begin
         r.ov  = 1'b1;
         r.val = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r.ov  = 1'b1;
         r.val = 32'sh80000000;
      end
      return r;
   endfunction

   // k * c, saturated: derivative weight of coefficient k
   function automatic sat_type weight(input logic signed [DATA_W-1:0] c,
                                      input logic [IDX_W-1:0] k);
      logic signed [35:0] p;
      p = 36'(c) * $signed({33'b0, k});
      return sat32(64'(p));
   endfunction

endpackage

// ===== sv/pvs_cell.sv =====
// ----------------------------------------------------------------------------
// pvs_cell: one Horner step for value and slope
// Stage A multiplies the running value and slope by x; stage B truncates,
// saturates and adds the coefficient and the derivative weight.
// ----------------------------------------------------------------------------
module pvs_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [pvs_pkg::DATA_W-1:0] coef,
   input  logic signed [pvs_pkg::DATA_W-1:0] wt,
   input  logic                            wt_ov,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  pvs_pkg::lane_type               in_lane,
   output logic                            out_valid,
   input  logic                            out_ready,
   output pvs_pkg::lane_type               out_lane
);

   logic                                  a_v_ff;
   logic signed [pvs_pkg::DATA_W-1:0]     a_x_ff;
   logic signed [63:0]                    a_pv_ff;
   logic signed [63:0]                    a_ps_ff;
   logic                                  a_ov_ff;
   logic                                  b_v_ff;
   pvs_pkg::lane_type                     b_lane_ff;
   pvs_pkg::lane_type                     b_lane_in;
   logic                                  rdy_a;
   logic                                  rdy_b;
   pvs_pkg::sat_type                      qv, qs, sv, ss;

   assign rdy_b    = !b_v_ff || out_ready;
   assign rdy_a    = !a_v_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      qv = pvs_pkg::sat32(a_pv_ff >>> pvs_pkg::FRAC_W);
      qs = pvs_pkg::sat32(a_ps_ff >>> pvs_pkg::FRAC_W);
      sv = pvs_pkg::sat32(64'(qv.val) + 64'(coef));
      ss = pvs_pkg::sat32(64'(qs.val) + 64'(wt));
      b_lane_in.x     = a_x_ff;
      b_lane_in.val   = sv.val;
      b_lane_in.slope = ss.val;
      b_lane_in.ov    = a_ov_ff | qv.ov | qs.ov | sv.ov | ss.ov | wt_ov;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            a_v_ff <= in_valid;
         end
         if (rdy_b) begin
            b_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         a_x_ff  <= in_lane.x;
         a_pv_ff <= 64'(in_lane.x) * 64'(in_lane.val);
         a_ps_ff <= 64'(in_lane.x) * 64'(in_lane.slope);
         a_ov_ff <= in_lane.ov;
      end
      if (rdy_b && a_v_ff) begin
         b_lane_ff <= b_lane_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_lane  = b_lane_ff;

endmodule

// ===== sv/polynomial_value_and_slope.sv =====
// ----------------------------------------------------------------------------
// polynomial_value_and_slope: Horner evaluation of a polynomial and its slope
// Evaluates p(x) and p'(x) in Q16.16 for up to MAX_TERMS coefficients.
// ----------------------------------------------------------------------------
// One sample time is taken per beat and one result leaves per beat, every
// cycle when the result side keeps up. A sample passes through the chain of
// MAX_TERMS-1 cells, each a multiply stage and an add stage, then through
// the output register; the latency does not depend on term_count, because
// unused high terms enter the chain as zeros. Write term_count and
// coefficients only while no sample is in flight.
module polynomial_value_and_slope #(
   parameter int MAX_TERMS = pvs_pkg::MAX_TERMS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pvs_pkg::DATA_W-1:0]        req_tdata,  // [31:0] sample_time
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] poly_value, [63:32] poly_slope, [64] overflow, [71:65] zero
   output logic [pvs_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pvs_pkg::IDX_W-1:0]         csr_index,
   input  logic [pvs_pkg::DATA_W-1:0]        csr_data
);

   localparam int NCELL = MAX_TERMS - 1;

   logic [pvs_pkg::TERM_W-1:0]            term_count_ff;
   logic signed [pvs_pkg::DATA_W-1:0]     coef_ff [pvs_pkg::COEF_REGS];
   logic signed [pvs_pkg::DATA_W-1:0]     wt_ff   [pvs_pkg::COEF_REGS];
   logic                                  wov_ff  [pvs_pkg::COEF_REGS];
   pvs_pkg::sat_type                      wt_new  [pvs_pkg::COEF_REGS];
   logic [pvs_pkg::TERM_W-1:0]            n_eff;
   logic signed [pvs_pkg::DATA_W-1:0]     ceff [MAX_TERMS];
   logic signed [pvs_pkg::DATA_W-1:0]     weff [MAX_TERMS];
   logic                                  wovf [MAX_TERMS];
   logic                                  lane_v   [NCELL+1];
   logic                                  lane_rdy [NCELL+1];
   pvs_pkg::lane_type                     lane     [NCELL+1];
   logic                                  out_v_ff;
   pvs_pkg::lane_type                     out_ff;
   pvs_pkg::reg_idx_type                  widx;

   // configuration
   assign csr_ready = 1'b1;
   assign widx      = pvs_pkg::reg_idx_type'(csr_index);

   always_comb begin
      for (int k = 0; k < pvs_pkg::COEF_REGS; k++) begin
         wt_new[k] = pvs_pkg::weight(csr_data, pvs_pkg::IDX_W'(k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= pvs_pkg::TERM_W'(1);
         for (int k = 0; k < pvs_pkg::COEF_REGS; k++) begin
            coef_ff[k] <= '0;
            wt_ff[k]   <= '0;
            wov_ff[k]  <= 1'b0;
         end
      end else if (csr_valid) begin
         if (widx == pvs_pkg::REG_TERM_COUNT) begin
            term_count_ff <= csr_data[pvs_pkg::TERM_W-1:0];
         end
         for (int k = 0; k < pvs_pkg::COEF_REGS; k++) begin
            if (csr_index == pvs_pkg::IDX_W'(k + 1)) begin
               coef_ff[k] <= csr_data;
               wt_ff[k]   <= wt_new[k].val;
               wov_ff[k]  <= wt_new[k].ov;
            end
         end
      end
   end

   always_comb begin
      n_eff = term_count_ff;
      if (term_count_ff == '0) begin
         n_eff = pvs_pkg::TERM_W'(1);
      end else if (term_count_ff > pvs_pkg::TERM_W'(MAX_TERMS)) begin
         n_eff = pvs_pkg::TERM_W'(MAX_TERMS);
      end
   end

   // coefficients at or above the term count enter as zero
   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_coef
      if (k < pvs_pkg::COEF_REGS) begin : g_reg
         logic used;
         assign used    = pvs_pkg::TERM_W'(k) < n_eff;
         assign ceff[k] = used ? coef_ff[k] : '0;
         assign weff[k] = used ? wt_ff[k] : '0;
         assign wovf[k] = used & wov_ff[k];
      end else begin : g_zero
         assign ceff[k] = '0;
         assign weff[k] = '0;
         assign wovf[k] = 1'b0;
      end
   end

   // chain head
   assign lane_v[0]      = req_tvalid;
   assign req_tready     = lane_rdy[0];
   assign lane[0].x      = req_tdata;
   assign lane[0].val    = ceff[MAX_TERMS-1];
   assign lane[0].slope  = '0;
   assign lane[0].ov     = 1'b0;

   // cell s folds in coefficient i-1 and weight i, with i = MAX_TERMS-1-s
   for (genvar s = 0; s < NCELL; s++) begin : g_cell
      pvs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef      (ceff[MAX_TERMS-2-s]),
         .wt        (weff[MAX_TERMS-1-s]),
         .wt_ov     (wovf[MAX_TERMS-1-s]),
         .in_valid  (lane_v[s]),
         .in_ready  (lane_rdy[s]),
         .in_lane   (lane[s]),
         .out_valid (lane_v[s+1]),
         .out_ready (lane_rdy[s+1]),
         .out_lane  (lane[s+1])
      );
   end

   // output register
   assign lane_rdy[NCELL] = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (lane_rdy[NCELL]) begin
         out_v_ff <= lane_v[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (lane_rdy[NCELL] && lane_v[NCELL]) begin
         out_ff <= lane[NCELL];
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'b0, out_ff.ov, out_ff.slope, out_ff.val};

endmodule
